### src/assert_macros.svh
// Assertion macros for the calculator block.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### src/icfr_pkg.sv
`default_nettype none
package icfr_pkg;

    // Operation codes.
    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_SUB  = 3'd1;
    localparam logic [2:0] FN_MUL  = 3'd2;
    localparam logic [2:0] FN_DIV  = 3'd3;
    localparam logic [2:0] FN_POW  = 3'd4;
    localparam logic [2:0] FN_FACT = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [7:0]  EXP_INT = 8'd158;
    localparam logic [4:0]  DIV_BITS = 5'd25;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } calc_in_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic [1:0]  status;
    } calc_out_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ARITH, OP_CONV_ARITH, OP_CONV_A, OP_CONV_B, OP_CONV_K,
        OP_CONV_STEP, OP_SAVE_RES, OP_SAVE_FA, OP_SAVE_FB, OP_DIV_INIT, OP_DIV_STEP,
        OP_DIV_FIN, OP_MUL1, OP_MUL2, OP_FIN_R, OP_SET_ERR1, OP_SET_ERR2,
        OP_SET_UNIT, OP_PUBLISH
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_ARITH, S_DECODE, S_CONV, S_ARITH_SAVE, S_DIV_A_SAVE, S_DIV_B,
        S_DIV_B_SAVE, S_DIV_INIT, S_DIV_RUN, S_POW_A_SAVE, S_CHECK, S_FACT_SAVE,
        S_MUL1, S_MUL2, S_PUBLISH
    } state_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       b_zero;
        logic       b_neg;
        logic       a_neg;
        logic       a_unit;
        logic       conv_done;
        logic       div_done;
        logic       cnt_zero;
        logic       r_inf;
        logic       r_zero;
    } dp_status_t;

    // Round to nearest even and pack; exponents at or above 255 become infinity.
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [10:0] exp_in,
                                               input logic [23:0] mant,
                                               input logic guard,
                                               input logic sticky);
        logic              up;
        logic [24:0]       m;
        logic signed [10:0] e;
        up = guard & (sticky | mant[0]);
        m  = {1'b0, mant} + 25'(up);
        e  = exp_in;
        if (m[24]) begin
            e = e + 11'sd1;
            m = {1'b0, 24'h80_0000};
        end
        if (e >= 11'sd255) begin
            return {sign, 8'hFF, 23'd0};
        end
        return {sign, e[7:0], m[22:0]};
    endfunction

endpackage
`default_nettype wire

### src/icfr_dp.sv
`default_nettype none
module icfr_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire icfr_pkg::ctrl_cmd_t cmd,
    input  wire icfr_pkg::calc_in_t in_data,
    output icfr_pkg::dp_status_t    stat,
    output icfr_pkg::calc_out_t     out_data
);
    import icfr_pkg::*;

    logic [2:0]         func_reg;
    logic [31:0]        a_reg, b_reg, arith_reg, cnt_reg;
    logic [31:0]        conv_val_reg;
    logic [7:0]         conv_exp_reg;
    logic               conv_sign_reg;
    logic [31:0]        fa_reg, fb_reg, r_reg, res_reg;
    logic [1:0]         status_reg;
    logic [47:0]        prod_reg;
    logic signed [10:0] pexp_reg, dexp_reg;
    logic               psign_reg, pzero_reg, dsign_reg;
    logic [24:0]        rem_reg, q_reg;
    logic [4:0]         dcnt_reg;
    calc_out_t          out_reg;

    logic [31:0] conv_float, conv_src, conv_mag;
    logic [23:0] ma, mf, mb, da;
    logic [24:0] diff;
    logic [31:0] mul_round;

    // Converter result from the normalized magnitude.
    always_comb
    begin
        if (conv_val_reg == 32'd0)
            conv_float = 32'd0;
        else
            conv_float = round_pack(conv_sign_reg, 11'({3'b000, conv_exp_reg}),
                                    conv_val_reg[31:8], conv_val_reg[7],
                                    |conv_val_reg[6:0]);
    end

    // Source of a new conversion.
    always_comb
    begin
        case (cmd.op)
            OP_CONV_A: conv_src = a_reg;
            OP_CONV_B: conv_src = b_reg;
            OP_CONV_K: conv_src = cnt_reg;
            default:   conv_src = arith_reg;
        endcase
        conv_mag = conv_src[31] ? (32'd0 - conv_src) : conv_src;
    end

    // Mantissas with the hidden bit.
    assign ma = {r_reg[30:23] != 8'd0, r_reg[22:0]};
    assign mf = {fa_reg[30:23] != 8'd0, fa_reg[22:0]};
    assign da = {1'b1, fa_reg[22:0]};
    assign mb = {1'b1, fb_reg[22:0]};
    assign diff = rem_reg - {1'b0, mb};

    // Normalize and round the registered product.
    always_comb
    begin
        if (prod_reg[47])
            mul_round = round_pack(psign_reg, pexp_reg + 11'sd1, prod_reg[47:24],
                                   prod_reg[23], |prod_reg[22:0]);
        else
            mul_round = round_pack(psign_reg, pexp_reg, prod_reg[46:23],
                                   prod_reg[22], |prod_reg[21:0]);
    end

    // Datapath registers, driven by the controller's command.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg   <= in_data.func;
                a_reg      <= in_data.operand_a;
                b_reg      <= in_data.operand_b;
                r_reg      <= FP_ONE;
                cnt_reg    <= (in_data.func == FN_FACT) ? in_data.operand_a
                                                        : in_data.operand_b;
                res_reg    <= 32'd0;
                status_reg <= ST_OK;
            end
            OP_ARITH:
            begin
                case (func_reg)
                    FN_ADD:  arith_reg <= a_reg + b_reg;
                    FN_SUB:  arith_reg <= a_reg - b_reg;
                    default: arith_reg <= 32'(a_reg * b_reg);
                endcase
            end
            OP_CONV_ARITH, OP_CONV_A, OP_CONV_B, OP_CONV_K:
            begin
                conv_val_reg  <= conv_mag;
                conv_sign_reg <= conv_src[31];
                conv_exp_reg  <= EXP_INT;
            end
            OP_CONV_STEP:
            begin
                if (conv_val_reg[31:24] == 8'd0)
                begin
                    conv_val_reg <= {conv_val_reg[23:0], 8'd0};
                    conv_exp_reg <= conv_exp_reg - 8'd8;
                end
                else if (!conv_val_reg[31])
                begin
                    conv_val_reg <= {conv_val_reg[30:0], 1'b0};
                    conv_exp_reg <= conv_exp_reg - 8'd1;
                end
            end
            OP_SAVE_RES: res_reg <= conv_float;
            OP_SAVE_FA:  fa_reg  <= conv_float;
            OP_SAVE_FB:  fb_reg  <= conv_float;
            OP_DIV_INIT:
            begin
                dsign_reg <= fa_reg[31] ^ fb_reg[31];
                q_reg     <= 25'd0;
                dcnt_reg  <= DIV_BITS;
                if (da < mb)
                begin
                    rem_reg  <= {da, 1'b0};
                    dexp_reg <= 11'({3'b000, fa_reg[30:23]}) - 11'({3'b000, fb_reg[30:23]})
                                + 11'sd126;
                end
                else
                begin
                    rem_reg  <= {1'b0, da};
                    dexp_reg <= 11'({3'b000, fa_reg[30:23]}) - 11'({3'b000, fb_reg[30:23]})
                                + 11'sd127;
                end
            end
            OP_DIV_STEP:
            begin
                dcnt_reg <= dcnt_reg - 5'd1;
                if (rem_reg >= {1'b0, mb})
                begin
                    rem_reg <= {diff[23:0], 1'b0};
                    q_reg   <= {q_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[23:0], 1'b0};
                    q_reg   <= {q_reg[23:0], 1'b0};
                end
            end
            OP_DIV_FIN:
            begin
                // A zero dividend gives a zero carrying the sign of the quotient.
                if (fa_reg[30:0] == 31'd0)
                    res_reg <= {dsign_reg, 31'd0};
                else
                    res_reg <= round_pack(dsign_reg, dexp_reg, q_reg[24:1], q_reg[0],
                                          rem_reg != 25'd0);
            end
            OP_MUL1:
            begin
                prod_reg  <= ma * mf;
                pexp_reg  <= 11'({3'b000, r_reg[30:23]}) + 11'({3'b000, fa_reg[30:23]})
                             - 11'sd127;
                psign_reg <= r_reg[31] ^ fa_reg[31];
                pzero_reg <= (r_reg[30:23] == 8'd0) || (fa_reg[30:23] == 8'd0);
                cnt_reg   <= cnt_reg - 32'd1;
            end
            OP_MUL2: r_reg <= pzero_reg ? 32'd0 : mul_round;
            OP_FIN_R:
                res_reg <= {r_reg[31] ^ (stat.r_inf & a_reg[31] & cnt_reg[0]), r_reg[30:0]};
            OP_SET_ERR1: status_reg <= ST_DIV0;
            OP_SET_ERR2: status_reg <= ST_NEG;
            OP_SET_UNIT: res_reg <= {a_reg[31] & b_reg[0], FP_ONE[30:0]};
            default: ;
        endcase
    end

    // Output register, loaded when the result is published.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (cmd.op == OP_PUBLISH)
        begin
            out_reg.result_bits <= res_reg;
            out_reg.status      <= status_reg;
        end
    end

    // Flags for the controller.
    always_comb
    begin
        stat.func      = func_reg;
        stat.b_zero    = (b_reg == 32'd0);
        stat.b_neg     = b_reg[31];
        stat.a_neg     = a_reg[31];
        stat.a_unit    = (a_reg == 32'd1) || (a_reg == 32'hFFFF_FFFF);
        stat.conv_done = conv_val_reg[31] || (conv_val_reg == 32'd0);
        stat.div_done  = (dcnt_reg == 5'd0);
        stat.cnt_zero  = (cnt_reg == 32'd0);
        stat.r_inf     = (r_reg[30:23] == 8'hFF);
        stat.r_zero    = (r_reg[30:0] == 31'd0);
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

### src/icfr_ctrl.sv
`default_nettype none
module icfr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire icfr_pkg::dp_status_t stat,
    output icfr_pkg::ctrl_cmd_t      cmd
);
    import icfr_pkg::*;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;
    logic   stop;

    // State, return point and output flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stop = stat.r_inf || stat.r_zero || stat.cnt_zero;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cmd.op         = OP_NONE;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ARITH;
                end
            S_ARITH:
            begin
                cmd.op     = OP_ARITH;
                state_next = S_DECODE;
            end
            S_DECODE:
                case (stat.func)
                    FN_ADD, FN_SUB, FN_MUL:
                    begin
                        cmd.op     = OP_CONV_ARITH;
                        ret_next   = S_ARITH_SAVE;
                        state_next = S_CONV;
                    end
                    FN_DIV:
                        if (stat.b_zero)
                        begin
                            cmd.op     = OP_SET_ERR1;
                            state_next = S_PUBLISH;
                        end
                        else
                        begin
                            cmd.op     = OP_CONV_A;
                            ret_next   = S_DIV_A_SAVE;
                            state_next = S_CONV;
                        end
                    FN_POW:
                        if (stat.b_neg)
                        begin
                            cmd.op     = OP_SET_ERR2;
                            state_next = S_PUBLISH;
                        end
                        else if (stat.a_unit)
                        begin
                            cmd.op     = OP_SET_UNIT;
                            state_next = S_PUBLISH;
                        end
                        else
                        begin
                            cmd.op     = OP_CONV_A;
                            ret_next   = S_POW_A_SAVE;
                            state_next = S_CONV;
                        end
                    FN_FACT:
                        if (stat.a_neg)
                        begin
                            cmd.op     = OP_SET_ERR2;
                            state_next = S_PUBLISH;
                        end
                        else
                            state_next = S_CHECK;
                    default: state_next = S_PUBLISH;
                endcase
            S_CONV:
                if (stat.conv_done)
                    state_next = ret_reg;
                else
                    cmd.op = OP_CONV_STEP;
            S_ARITH_SAVE:
            begin
                cmd.op     = OP_SAVE_RES;
                state_next = S_PUBLISH;
            end
            S_DIV_A_SAVE:
            begin
                cmd.op     = OP_SAVE_FA;
                state_next = S_DIV_B;
            end
            S_DIV_B:
            begin
                cmd.op     = OP_CONV_B;
                ret_next   = S_DIV_B_SAVE;
                state_next = S_CONV;
            end
            S_DIV_B_SAVE:
            begin
                cmd.op     = OP_SAVE_FB;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
                if (stat.div_done)
                begin
                    cmd.op     = OP_DIV_FIN;
                    state_next = S_PUBLISH;
                end
                else
                    cmd.op = OP_DIV_STEP;
            S_POW_A_SAVE:
            begin
                cmd.op     = OP_SAVE_FA;
                state_next = S_CHECK;
            end
            S_CHECK:
                if (stop)
                begin
                    cmd.op     = OP_FIN_R;
                    state_next = S_PUBLISH;
                end
                else if (stat.func == FN_POW)
                    state_next = S_MUL1;
                else
                begin
                    cmd.op     = OP_CONV_K;
                    ret_next   = S_FACT_SAVE;
                    state_next = S_CONV;
                end
            S_FACT_SAVE:
            begin
                cmd.op     = OP_SAVE_FA;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = S_CHECK;
            end
            S_PUBLISH:
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

### src/int_calculator_float_result.sv
// Integer calculator with a single-precision float result.
// Input channel: in_valid / in_stall carry one item (func, operand_a, operand_b).
// Output channel: out_valid / out_stall carry one item (result_bits, status).
// One item is worked on at a time; in_stall is high from acceptance until the
// result has been moved into the output register.
// Add, subtract and multiply run one conversion in the shared int-to-float
// normalizer (8 bits or 1 bit per cycle). Divide runs two conversions and a
// 25-step restoring divider. Power runs one float multiply per factor,
// factorial one conversion and one float multiply per factor; both stop at
// infinity, zero or a spent count, so at most about 130 factors. Errors,
// unit bases and unused codes go from decode straight to publish.
// The output register lets a new item be accepted while a result waits;
// a stalled result holds, and the next result waits in the datapath.
// Reset clears the controller, the output register and the output valid flag.
`default_nettype none
`include "assert_macros.svh"
module int_calculator_float_result (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire icfr_pkg::calc_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output icfr_pkg::calc_out_t     out_data
);
    import icfr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    icfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    icfr_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_data (in_data),
        .stat    (stat),
        .out_data(out_data)
    );

    // An accepted item blocks the input until its result is published.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not blocked")
    // The status code is never the unused one.
    `ASSERT_SAME(a_status_valid, clk, rst_n, out_valid, out_data.status != ST_BAD, "bad status")
    // A divide by zero gives a zero result.
    `ASSERT_SAME(a_div0_zero, clk, rst_n, out_valid && out_data.status == ST_DIV0, out_data.result_bits == 32'd0, "div0 result nonzero")

endmodule
`default_nettype wire
